>>> src/lbmrc_pkg.sv
`timescale 1ns / 1ps

package lbmrc_pkg;

    localparam int NUM_STAGES = 11;

    typedef logic [NUM_STAGES:1] stage_en_t;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t REG_INV_RELAX_TIME  = 2'd0;
    localparam cfg_index_t REG_REACTION_GAIN   = 2'd1;
    localparam cfg_index_t REG_REACTION_OFFSET = 2'd2;

    localparam logic [25:0]        INV_RELAX_TIME_RST  = 26'd16777216;
    localparam logic [30:0]        REACTION_GAIN_RST   = 31'd16777216;
    localparam logic signed [31:0] REACTION_OFFSET_RST = 32'sd1677722;

    localparam logic signed [63:0] Q_ONE  = 64'sd16777216;
    localparam logic signed [63:0] Q_MAX  = 64'sd2147483647;
    localparam logic signed [63:0] Q_MIN  = -64'sd2147483648;

    localparam logic signed [63:0] RND_24  = 64'sd8388608;
    localparam logic signed [63:0] RND_EQ3 = 64'sd25165824;
    localparam logic signed [63:0] RND_EQ6 = 64'sd50331648;

    localparam logic signed [63:0] DIV3_HI   = 64'sd6442450943;
    localparam logic signed [63:0] DIV3_LO   = -64'sd6442450944;
    localparam logic signed [63:0] DIV3_BIAS = 64'sd6442450944;
    localparam logic [30:0]        DIV3_RECIP = 31'h5555_5555;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        r = x[31:0];
        if (x > Q_MAX)
        begin
            r = 32'sh7fff_ffff;
        end
        else if (x < Q_MIN)
        begin
            r = 32'sh8000_0000;
        end
        return r;
    endfunction

    // clamp so that floor(t/3) saturates, then bias into the unsigned range
    function automatic logic [33:0] div3_arg(input logic signed [63:0] t);
        logic signed [63:0] clamped;
        clamped = t;
        if (t > DIV3_HI)
        begin
            clamped = DIV3_HI;
        end
        else if (t < DIV3_LO)
        begin
            clamped = DIV3_LO;
        end
        clamped = clamped + DIV3_BIAS;
        return clamped[33:0];
    endfunction

endpackage

>>> src/lbm_d2q5_reaction_collide_unit.sv
`timescale 1ns / 1ps

// D2Q5 BGK collision with a reaction source, one lattice node per beat.
// Input channel: in_valid / in_stall carry the five distributions, the
// velocity, the partner concentration and the outside flag of one node.
// Output channel: out_valid / out_stall carry the relaxed, swapped
// distributions and the node concentration of that node.
// Config port: cfg_wr_en writes cfg_data to the register cfg_index
// (0 inverse relaxation time, 1 reaction gain, 2 reaction offset);
// write only while no beat is in flight.
// Pipeline: 11 register stages; the result and node concentration of a
// beat leave from the last stage.
// Throughput: one node per cycle; every stage takes a beat unless stalled.
// Stall: a stalled output holds its beat; stages behind it keep filling
// bubbles, and in_stall rises only once every stage holds a beat.
// Reset: all stages empty, registers at 1.0, 1.0 and 0.1.
module lbm_d2q5_reaction_collide_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] dist_rest,
    input  logic signed [31:0] dist_east,
    input  logic signed [31:0] dist_north,
    input  logic signed [31:0] dist_west,
    input  logic signed [31:0] dist_south,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] partner_conc,
    input  logic               outside_domain,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] new_rest,
    output logic signed [31:0] new_east,
    output logic signed [31:0] new_north,
    output logic signed [31:0] new_west,
    output logic signed [31:0] new_south,
    output logic signed [31:0] node_conc,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int NS         = lbmrc_pkg::NUM_STAGES;
    localparam int LANE_REST  = 0;
    localparam int LANE_EAST  = 1;
    localparam int LANE_NORTH = 2;
    localparam int LANE_WEST  = 3;
    localparam int LANE_SOUTH = 4;

    logic [25:0]        tau_reg;
    logic [30:0]        gain_reg;
    logic signed [31:0] offset_reg;

    lbmrc_pkg::stage_en_t stage_en;
    logic [NS:1]          valid_reg;
    logic [NS:1]          valid_next;

    logic signed [63:0] sum_all;
    logic signed [31:0] conc_next;
    logic signed [31:0] conc_reg [1:NS];
    logic signed [31:0] f_next [1:4];
    logic signed [31:0] f_reg [1:4];
    logic signed [31:0] dist_reg [1:5][0:4];
    logic signed [31:0] cv_reg [1:3];
    logic               outside_reg [1:3];

    logic signed [63:0] pm_next [1:4];
    logic signed [63:0] pm_reg [1:4];
    logic signed [63:0] pcc_next;
    logic signed [63:0] pcc_reg;
    logic signed [63:0] xr_full;
    logic [33:0]        xr_reg;

    logic [33:0]        x_next [0:4];
    logic [33:0]        x_reg [0:4];
    logic signed [31:0] cc_next;
    logic signed [31:0] cc_reg;

    logic signed [31:0] eq [0:4];
    logic signed [31:0] rxn_rest;
    logic signed [31:0] rxn_move;
    logic signed [31:0] lane_out [0:4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tau_reg    <= lbmrc_pkg::INV_RELAX_TIME_RST;
            gain_reg   <= lbmrc_pkg::REACTION_GAIN_RST;
            offset_reg <= lbmrc_pkg::REACTION_OFFSET_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                lbmrc_pkg::REG_INV_RELAX_TIME:  tau_reg    <= cfg_data[25:0];
                lbmrc_pkg::REG_REACTION_GAIN:   gain_reg   <= cfg_data[30:0];
                lbmrc_pkg::REG_REACTION_OFFSET: offset_reg <= signed'(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    // advance a stage when it is empty or the stage ahead advances
    always_comb
    begin
        stage_en[NS] = !valid_reg[NS] || !out_stall;
        for (int k = NS - 1; k >= 1; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k + 1];
        end
    end

    assign valid_next = {valid_reg[NS-1:1], in_valid};
    assign in_stall   = !stage_en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= NS; k++)
            begin
                if (stage_en[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    assign sum_all = 64'(dist_rest) + 64'(dist_east) + 64'(dist_north)
                   + 64'(dist_west) + 64'(dist_south);
    assign conc_next = lbmrc_pkg::sat32(sum_all);

    assign f_next[LANE_EAST]  = lbmrc_pkg::sat32(lbmrc_pkg::Q_ONE + 64'sd3 * 64'(vel_x));
    assign f_next[LANE_WEST]  = lbmrc_pkg::sat32(lbmrc_pkg::Q_ONE - 64'sd3 * 64'(vel_x));
    assign f_next[LANE_NORTH] = lbmrc_pkg::sat32(lbmrc_pkg::Q_ONE + 64'sd3 * 64'(vel_y));
    assign f_next[LANE_SOUTH] = lbmrc_pkg::sat32(lbmrc_pkg::Q_ONE - 64'sd3 * 64'(vel_y));

    always_comb
    begin
        x_next[LANE_REST] = xr_reg;
        for (int l = 1; l <= 4; l++)
        begin
            pm_next[l] = 64'(conc_reg[1]) * 64'(f_reg[l]);
            x_next[l]  = lbmrc_pkg::div3_arg((pm_reg[l] + lbmrc_pkg::RND_EQ6) >>> 25);
        end
    end

    assign pcc_next  = 64'(conc_reg[1]) * 64'(conc_reg[1]);
    assign xr_full   = 64'(conc_reg[1]) + 64'sd1 + lbmrc_pkg::DIV3_BIAS;
    assign cc_next   = lbmrc_pkg::sat32((pcc_reg + lbmrc_pkg::RND_24) >>> 24);

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            conc_reg[1]            <= conc_next;
            f_reg                  <= f_next;
            dist_reg[1][LANE_REST]  <= dist_rest;
            dist_reg[1][LANE_EAST]  <= dist_east;
            dist_reg[1][LANE_NORTH] <= dist_north;
            dist_reg[1][LANE_WEST]  <= dist_west;
            dist_reg[1][LANE_SOUTH] <= dist_south;
            cv_reg[1]              <= partner_conc;
            outside_reg[1]         <= outside_domain;
        end
        if (stage_en[2])
        begin
            pm_reg         <= pm_next;
            pcc_reg        <= pcc_next;
            xr_reg         <= xr_full[33:0];
            cv_reg[2]      <= cv_reg[1];
            outside_reg[2] <= outside_reg[1];
        end
        if (stage_en[3])
        begin
            x_reg          <= x_next;
            cc_reg         <= cc_next;
            cv_reg[3]      <= cv_reg[2];
            outside_reg[3] <= outside_reg[2];
        end
        for (int k = 2; k <= NS; k++)
        begin
            if (stage_en[k])
            begin
                conc_reg[k] <= conc_reg[k - 1];
            end
        end
        for (int k = 2; k <= 5; k++)
        begin
            if (stage_en[k])
            begin
                dist_reg[k] <= dist_reg[k - 1];
            end
        end
    end

    lbmrc_reaction u_reaction (
        .clk      (clk),
        .stage_en (stage_en),
        .gain     (gain_reg),
        .offset   (offset_reg),
        .cc       (cc_reg),
        .cv       (cv_reg[3]),
        .outside  (outside_reg[3]),
        .conc     (conc_reg[5]),
        .rxn_rest (rxn_rest),
        .rxn_move (rxn_move)
    );

    for (genvar g = 0; g < 5; g++)
    begin : g_lane
        lbmrc_div3 u_div_eq (
            .clk (clk),
            .en  (stage_en[5:4]),
            .x   (x_reg[g]),
            .q   (eq[g])
        );

        lbmrc_relax_lane u_relax (
            .clk       (clk),
            .stage_en  (stage_en),
            .tau       (tau_reg),
            .eq        (eq[g]),
            .slot_dist (dist_reg[5][g]),
            .rxn       ((g == LANE_REST) ? rxn_rest : rxn_move),
            .result    (lane_out[g])
        );
    end

    assign out_valid = valid_reg[NS];
    assign new_rest  = lane_out[LANE_REST];
    assign new_east  = lane_out[LANE_WEST];
    assign new_north = lane_out[LANE_SOUTH];
    assign new_west  = lane_out[LANE_EAST];
    assign new_south = lane_out[LANE_NORTH];
    assign node_conc = conc_reg[NS];

endmodule

>>> src/lbmrc_div3.sv
`timescale 1ns / 1ps

module lbmrc_div3 (
    input  logic               clk,
    input  logic [1:0]         en,
    input  logic [33:0]        x,
    output logic signed [31:0] q
);

    logic [63:0]        prod;
    logic [31:0]        q_est_next;
    logic [31:0]        q_est_reg;
    logic [33:0]        x_reg;
    logic [2:0]         three_q;
    logic [2:0]         rem;
    logic [31:0]        q_fix;
    logic signed [31:0] q_next;
    logic signed [31:0] q_reg;

    assign prod       = {30'b0, x} * {33'b0, lbmrc_pkg::DIV3_RECIP};
    assign q_est_next = prod[63:32];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            q_est_reg <= q_est_next;
            x_reg     <= x;
        end
    end

    // estimate is low by at most one: fix from the low remainder bits
    assign three_q = {q_est_reg[1:0], 1'b0} + q_est_reg[2:0];
    assign rem     = x_reg[2:0] - three_q;
    assign q_fix   = q_est_reg + {31'b0, (rem >= 3'd3)};
    assign q_next  = signed'({~q_fix[31], q_fix[30:0]});

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

>>> src/lbmrc_reaction.sv
`timescale 1ns / 1ps

module lbmrc_reaction (
    input  logic                  clk,
    input  lbmrc_pkg::stage_en_t  stage_en,
    input  logic [30:0]           gain,
    input  logic signed [31:0]    offset,
    input  logic signed [31:0]    cc,
    input  logic signed [31:0]    cv,
    input  logic                  outside,
    input  logic signed [31:0]    conc,
    output logic signed [31:0]    rxn_rest,
    output logic signed [31:0]    rxn_move
);

    logic signed [63:0] pp_next;
    logic signed [63:0] pp_reg;
    logic signed [31:0] p_next;
    logic signed [31:0] p_reg;
    logic signed [31:0] inner_next;
    logic signed [31:0] inner_reg;
    logic signed [63:0] term_next;
    logic signed [63:0] term_reg;
    logic [33:0]        x3_next;
    logic [33:0]        x6_next;
    logic [33:0]        x3_reg;
    logic [33:0]        x6_reg;
    logic [10:4]        outside_reg;
    logic signed [31:0] q3;
    logic signed [31:0] q6;

    assign pp_next    = 64'(cc) * 64'(cv);
    assign p_next     = lbmrc_pkg::sat32((pp_reg + lbmrc_pkg::RND_24) >>> 24);
    assign inner_next = lbmrc_pkg::sat32(64'(offset) - 64'(conc) + 64'(p_reg));
    assign term_next  = 64'(signed'({1'b0, gain})) * 64'(inner_reg);
    assign x3_next    = lbmrc_pkg::div3_arg((term_reg + lbmrc_pkg::RND_EQ3) >>> 24);
    assign x6_next    = lbmrc_pkg::div3_arg((term_reg + lbmrc_pkg::RND_EQ6) >>> 25);

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            pp_reg         <= pp_next;
            outside_reg[4] <= outside;
        end
        if (stage_en[5])
        begin
            p_reg          <= p_next;
            outside_reg[5] <= outside_reg[4];
        end
        if (stage_en[6])
        begin
            inner_reg      <= inner_next;
            outside_reg[6] <= outside_reg[5];
        end
        if (stage_en[7])
        begin
            term_reg       <= term_next;
            outside_reg[7] <= outside_reg[6];
        end
        if (stage_en[8])
        begin
            x3_reg         <= x3_next;
            x6_reg         <= x6_next;
            outside_reg[8] <= outside_reg[7];
        end
        if (stage_en[9])
        begin
            outside_reg[9] <= outside_reg[8];
        end
        if (stage_en[10])
        begin
            outside_reg[10] <= outside_reg[9];
        end
    end

    lbmrc_div3 u_div_rest (
        .clk (clk),
        .en  (stage_en[10:9]),
        .x   (x3_reg),
        .q   (q3)
    );

    lbmrc_div3 u_div_move (
        .clk (clk),
        .en  (stage_en[10:9]),
        .x   (x6_reg),
        .q   (q6)
    );

    assign rxn_rest = outside_reg[10] ? 32'sd0 : q3;
    assign rxn_move = outside_reg[10] ? 32'sd0 : q6;

endmodule

>>> src/lbmrc_relax_lane.sv
`timescale 1ns / 1ps

module lbmrc_relax_lane (
    input  logic                  clk,
    input  lbmrc_pkg::stage_en_t  stage_en,
    input  logic [25:0]           tau,
    input  logic signed [31:0]    eq,
    input  logic signed [31:0]    slot_dist,
    input  logic signed [31:0]    rxn,
    output logic signed [31:0]    result
);

    logic signed [32:0] diff_next;
    logic signed [32:0] diff_reg;
    logic signed [59:0] prod_next;
    logic signed [59:0] prod_reg;
    logic signed [59:0] prod_rnd;
    logic signed [35:0] delta_next;
    logic signed [35:0] delta_reg [8:10];
    logic signed [31:0] dist_reg [6:10];
    logic signed [31:0] result_next;
    logic signed [31:0] result_reg;

    assign diff_next   = 33'(eq) - 33'(slot_dist);
    assign prod_next   = 60'(signed'({1'b0, tau})) * 60'(diff_reg);
    assign prod_rnd    = prod_reg + 60'(lbmrc_pkg::RND_24);
    assign delta_next  = 36'(prod_rnd >>> 24);
    assign result_next = lbmrc_pkg::sat32(64'(dist_reg[10]) + 64'(delta_reg[10]) + 64'(rxn));

    always_ff @(posedge clk)
    begin
        if (stage_en[6])
        begin
            diff_reg    <= diff_next;
            dist_reg[6] <= slot_dist;
        end
        if (stage_en[7])
        begin
            prod_reg    <= prod_next;
            dist_reg[7] <= dist_reg[6];
        end
        if (stage_en[8])
        begin
            delta_reg[8] <= delta_next;
            dist_reg[8]  <= dist_reg[7];
        end
        if (stage_en[9])
        begin
            delta_reg[9] <= delta_reg[8];
            dist_reg[9]  <= dist_reg[8];
        end
        if (stage_en[10])
        begin
            delta_reg[10] <= delta_reg[9];
            dist_reg[10]  <= dist_reg[9];
        end
        if (stage_en[11])
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule
